@@ hdl/rsf_pkg.sv @@
`timescale 1ns / 1ps
// rsf_pkg: shared types and constants of the record sector fixup unit.
// No dependencies.
package rsf_pkg;

   localparam int unsigned WORD_W        = 16;
   localparam int unsigned SECTOR_W      = 12;
   localparam int unsigned SECPOS_W      = 11;
   localparam int unsigned OFFSET_W      = 15;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned CSR_ADDR_W    = 3;

   // register index taken from paddr[2]
   localparam logic REG_SECTOR_WORDS     = 1'b0;

   localparam logic [SECTOR_W-1:0] SECTOR_WORDS_RESET = 12'd256;
   localparam logic [SECTOR_W-1:0] SECTOR_WORDS_MIN   = 12'd16;
   localparam logic [SECTOR_W-1:0] SECTOR_WORDS_MAX   = 12'd2048;

   // header word positions
   localparam logic [WORD_W-1:0] POS_SEQ_OFFSET = 16'd2;
   localparam logic [WORD_W-1:0] POS_SEQ_COUNT  = 16'd3;
   localparam logic [WORD_W-1:0] POS_FIRST_BODY = 16'd4;

   // decision made at acceptance, carried alongside the memory read
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              check;   // sector end that must be checked
      logic              pass;    // check succeeded, substitute stored entry
      logic              fwd;     // entry written by this same transaction
   } ctl_type;

endpackage

@@ hdl/rsf_seq_ram.sv @@
`timescale 1ns / 1ps
// rsf_seq_ram: update-sequence store, one write and one registered read port.
// Read returns the old contents on a same-address write. Uses no package.
module rsf_seq_ram #(
   parameter int unsigned DEPTH  = 9,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_addr) < DEPTH)) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rsf_track.sv @@
`timescale 1ns / 1ps
// rsf_track: per-record position tracking, sequence capture and check decision.
// Depends on rsf_pkg; drives the write and read ports of rsf_seq_ram.
module rsf_track #(
   parameter int unsigned MAX_SECTORS = 8,
   parameter int unsigned ADDR_W      = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [rsf_pkg::WORD_W-1:0]        data_word,
   input  logic                              last_word,
   input  logic [rsf_pkg::SECTOR_W-1:0]      sector_words,
   output logic                              wr_en,
   output logic [ADDR_W-1:0]                 wr_addr,
   output logic [rsf_pkg::WORD_W-1:0]        wr_data,
   output logic [ADDR_W-1:0]                 rd_addr,
   output rsf_pkg::ctl_type                  ctl
);
   import rsf_pkg::*;

   localparam int unsigned CAPT_W = $clog2(MAX_SECTORS + 2);
   localparam int unsigned SECN_W = $clog2(MAX_SECTORS + 1);

   logic [WORD_W-1:0]   pos_ff, pos_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [WORD_W-1:0]   count_ff, count_in;
   logic [CAPT_W-1:0]   capt_ff, capt_in;
   logic [SECN_W-1:0]   secn_ff, secn_in;
   logic                abort_ff, abort_in;
   logic [SECPOS_W-1:0] spos_ff, spos_in;
   logic [WORD_W-1:0]   word0_ff, word0_in;

   logic [WORD_W-1:0]   idx;
   logic                cap;
   logic [CAPT_W-1:0]   idx_p1;
   logic [CAPT_W-1:0]   capt_new;
   logic [WORD_W-1:0]   word0_eff;
   logic [SECPOS_W-1:0] spos_end;
   logic                is_end;
   logic                sec_room;
   logic [CAPT_W-1:0]   entry_c;
   logic [WORD_W-1:0]   entry_w;
   logic [ADDR_W-1:0]   entry_a;
   logic                check;
   logic                pass;

   always_comb begin
      idx      = pos_ff - WORD_W'(off_ff);
      cap      = (pos_ff >= POS_FIRST_BODY) && (pos_ff >= WORD_W'(off_ff))
                 && (idx < count_ff) && (idx <= WORD_W'(MAX_SECTORS));
      idx_p1   = idx[CAPT_W-1:0] + CAPT_W'(1);
      capt_new = (cap && (capt_ff < idx_p1)) ? idx_p1 : capt_ff;
      word0_eff = (cap && (idx == '0)) ? data_word : word0_ff;

      spos_end = SECPOS_W'(sector_words - SECTOR_W'(1));
      is_end   = (spos_ff == spos_end);
      sec_room = (32'(secn_ff) < MAX_SECTORS);
      entry_c  = CAPT_W'(secn_ff) + CAPT_W'(1);
      entry_w  = WORD_W'(secn_ff) + WORD_W'(1);
      entry_a  = ADDR_W'(secn_ff) + ADDR_W'(1);

      check = is_end && !abort_ff && sec_room && (entry_w < count_ff);
      pass  = (capt_new > entry_c) && (data_word == word0_eff);
   end

   always_comb begin
      pos_in   = pos_ff;
      off_in   = off_ff;
      count_in = count_ff;
      capt_in  = capt_ff;
      secn_in  = secn_ff;
      abort_in = abort_ff;
      spos_in  = spos_ff;
      word0_in = word0_ff;
      if (accept) begin
         if (pos_ff == POS_SEQ_OFFSET) begin
            off_in = data_word[WORD_W-1:1];
         end else if (pos_ff == POS_SEQ_COUNT) begin
            count_in = data_word;
         end
         capt_in  = capt_new;
         word0_in = word0_eff;
         if (check && !pass) begin
            abort_in = 1'b1;
         end
         if (is_end && sec_room) begin
            secn_in = secn_ff + SECN_W'(1);
         end
         // sector offset follows pos % sector_words, including the 16-bit wrap
         if (is_end || (pos_ff == '1)) begin
            spos_in = '0;
         end else begin
            spos_in = spos_ff + SECPOS_W'(1);
         end
         pos_in = pos_ff + WORD_W'(1);
         if (last_word) begin
            pos_in   = '0;
            off_in   = '0;
            count_in = '0;
            capt_in  = '0;
            secn_in  = '0;
            abort_in = 1'b0;
            spos_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         off_ff   <= '0;
         count_ff <= '0;
         capt_ff  <= '0;
         secn_ff  <= '0;
         abort_ff <= 1'b0;
         spos_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         count_ff <= count_in;
         capt_ff  <= capt_in;
         secn_ff  <= secn_in;
         abort_ff <= abort_in;
         spos_ff  <= spos_in;
      end
   end

   always_ff @(posedge clock) begin
      word0_ff <= word0_in;
   end

   assign wr_en     = accept && cap;
   assign wr_addr   = idx[ADDR_W-1:0];
   assign wr_data   = data_word;
   assign rd_addr   = entry_a;

   assign ctl.word  = data_word;
   assign ctl.last  = last_word;
   assign ctl.check = check;
   assign ctl.pass  = pass;
   assign ctl.fwd   = cap && (idx[ADDR_W-1:0] == entry_a);

endmodule

@@ hdl/rsf_out.sv @@
`timescale 1ns / 1ps
// rsf_out: read-wait stage and output register with the channel handshakes.
// Depends on rsf_pkg; takes read data from rsf_seq_ram.
module rsf_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       accept,
   input  rsf_pkg::ctl_type           ctl,
   input  logic [rsf_pkg::WORD_W-1:0] rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rsf_pkg::WORD_W-1:0] rsp_out_word,
   output logic                       rsp_out_last,
   output logic                       rsp_replaced,
   output logic                       rsp_mismatch
);
   import rsf_pkg::*;

   ctl_type           p_ctl_ff;
   logic              p_valid_ff, p_valid_in;
   logic              o_valid_ff, o_valid_in;
   logic [WORD_W-1:0] o_word_ff;
   logic              o_last_ff, o_repl_ff, o_mis_ff;
   logic              adv;
   logic [WORD_W-1:0] sub_word;
   logic              do_repl;

   assign adv       = !o_valid_ff || !rsp_stall;
   assign req_stall = p_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (adv) begin
         p_valid_in = 1'b0;
      end
      o_valid_in = adv ? p_valid_ff : o_valid_ff;
      sub_word   = p_ctl_ff.fwd ? p_ctl_ff.word : rd_data;
      do_repl    = p_ctl_ff.check && p_ctl_ff.pass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_ctl_ff <= ctl;
      end
      if (adv && p_valid_ff) begin
         o_word_ff <= do_repl ? sub_word : p_ctl_ff.word;
         o_last_ff <= p_ctl_ff.last;
         o_repl_ff <= do_repl;
         o_mis_ff  <= p_ctl_ff.check && !p_ctl_ff.pass;
      end
   end

   assign rsp_valid    = o_valid_ff;
   assign rsp_out_word = o_word_ff;
   assign rsp_out_last = o_last_ff;
   assign rsp_replaced = o_repl_ff;
   assign rsp_mismatch = o_mis_ff;

endmodule

@@ hdl/record_sector_fixup_unit.sv @@
`timescale 1ns / 1ps
// record_sector_fixup_unit: top level of the update-sequence fixup.
// Depends on rsf_pkg, rsf_seq_ram, rsf_track and rsf_out.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_word, req_last_word
//   rsp      out        rsp_valid/rsp_stall  rsp_out_word, rsp_out_last,
//                                            rsp_replaced, rsp_mismatch
//   csr      in/out     psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One transaction per cycle sustained unless rsp stalls; each word waits in the
// read-wait stage for the sequence store read, then in the output register.
// Reset is synchronous; the sequence store is not cleared and needs no sweep,
// so the unit takes words in the first cycle after reset.
// A stall on rsp holds the output register; req stalls only once the
// read-wait stage is also full.
//
// Transaction flow: at acceptance the tracker decides capture and check from
// the record counters and the header fields, writes any sequence word into the
// store and reads the entry for the next sector end. A sector entry written by
// the same transaction that checks it is forwarded from the word itself, and
// sequence word 0 is kept in a register beside the store so both compare
// operands are available in the accept cycle.
module record_sector_fixup_unit #(
   parameter int unsigned MAX_SECTORS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rsf_pkg::WORD_W-1:0]     req_data_word,
   input  logic                           req_last_word,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rsf_pkg::WORD_W-1:0]     rsp_out_word,
   output logic                           rsp_out_last,
   output logic                           rsp_replaced,
   output logic                           rsp_mismatch,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rsf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rsf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rsf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import rsf_pkg::*;

   // store holds entries 0 .. MAX_SECTORS
   localparam int unsigned DEPTH  = MAX_SECTORS + 1;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic [SECTOR_W-1:0] sector_words_ff, sector_words_in;
   logic [SECTOR_W-1:0] wr_value;
   logic                csr_write;

   logic                accept;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]   rd_data;
   ctl_type             ctl;

   // configuration: sector size saturated into its legal range on write
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == REG_SECTOR_WORDS);

   always_comb begin
      wr_value = pwdata[SECTOR_W-1:0];
      if (wr_value < SECTOR_WORDS_MIN) begin
         wr_value = SECTOR_WORDS_MIN;
      end else if (wr_value > SECTOR_WORDS_MAX) begin
         wr_value = SECTOR_WORDS_MAX;
      end
      sector_words_in = csr_write ? wr_value : sector_words_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_words_ff <= SECTOR_WORDS_RESET;
      end else begin
         sector_words_ff <= sector_words_in;
      end
   end

   assign prdata = (paddr[2] == REG_SECTOR_WORDS)
                   ? CSR_DATA_W'(sector_words_ff) : '0;

   rsf_track #(
      .MAX_SECTORS (MAX_SECTORS),
      .ADDR_W      (ADDR_W)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_word    (req_data_word),
      .last_word    (req_last_word),
      .sector_words (sector_words_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .ctl          (ctl)
   );

   // read issued only with an accepted transaction, so read data holds
   // while that transaction waits in the read-wait stage
   rsf_seq_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_seq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsf_out u_out (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .accept       (accept),
      .ctl          (ctl),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_word (rsp_out_word),
      .rsp_out_last (rsp_out_last),
      .rsp_replaced (rsp_replaced),
      .rsp_mismatch (rsp_mismatch)
   );

endmodule

@@ hdl/rsf_checker.sv @@
`timescale 1ns / 1ps
// rsf_checker: port-level assertions for record_sector_fixup_unit, with bind.
// Depends on rsf_pkg.
module rsf_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [rsf_pkg::WORD_W-1:0] rsp_out_word,
   input  logic                       rsp_out_last,
   input  logic                       rsp_replaced,
   input  logic                       rsp_mismatch
);
   import rsf_pkg::*;

   logic       in_acc, out_acc;
   logic [1:0] pend_ff, pend_in;
   logic       err_ff, err_in;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (in_acc && !out_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (!in_acc && out_acc) begin
         pend_in = pend_ff - 2'd1;
      end
      err_in = err_ff;
      if (out_acc) begin
         err_in = rsp_out_last ? 1'b0 : (err_ff || rsp_mismatch);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         err_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         err_ff  <= err_in;
      end
   end

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_replaced && rsp_mismatch))
      else $error("replaced and mismatch both set");

   a_quiet_after_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && err_ff) |-> (!rsp_replaced && !rsp_mismatch))
      else $error("fixup activity after mismatch in the same record");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result with no transaction outstanding");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more transactions in flight than pipeline stages");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_word)))
      else $error("stalled result changed");

endmodule

bind record_sector_fixup_unit rsf_checker u_rsf_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for record_sector_fixup_unit.
// Depends on rsf_pkg and the record_sector_fixup_unit RTL only.
module testbench;
   import rsf_pkg::*;

   localparam int unsigned MAX_SECTORS  = 8;
   localparam int unsigned USA_IDX_W    = $clog2(MAX_SECTORS + 1);
   localparam int unsigned DRAIN_CYCLES = 8;       // two-stage pipe, plus margin
   localparam int unsigned DRAIN_LIMIT  = 100000;

   // register map: index taken from paddr[2], byte address 4*index
   localparam logic [CSR_ADDR_W-1:0] ADDR_SECTOR_WORDS = {REG_SECTOR_WORDS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED     = {~REG_SECTOR_WORDS, 2'b00};

   // one result transaction as seen on the rsp channel
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              replaced;
      logic              mismatch;
   } fixed_word_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [WORD_W-1:0]     req_data_word = '0;
   logic                  req_last_word = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [WORD_W-1:0]     rsp_out_word;
   logic                  rsp_out_last;
   logic                  rsp_replaced;
   logic                  rsp_mismatch;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [CSR_DATA_W-1:0] pwdata        = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   record_sector_fixup_unit #(.MAX_SECTORS(MAX_SECTORS)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_word (req_data_word),
      .req_last_word (req_last_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_word  (rsp_out_word),
      .rsp_out_last  (rsp_out_last),
      .rsp_replaced  (rsp_replaced),
      .rsp_mismatch  (rsp_mismatch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // -------------------------------------------------------------------------
   // Fixup predictor: mirror of the record tracking state and the one register
   // -------------------------------------------------------------------------
   int unsigned           sector_len;        // sector size in words, as programmed
   logic [WORD_W-1:0]     rec_pos;           // word position in the record, wraps
   logic [OFFSET_W-1:0]   usa_offset;        // sequence offset in words
   logic [WORD_W-1:0]     usa_count;         // sequence length from header word 3
   logic [WORD_W-1:0]     usa_words [0:MAX_SECTORS];
   int unsigned           usa_filled;        // high-water mark of captured entries
   int unsigned           sectors_seen;      // sector ends, saturating
   bit                    fixup_stopped;     // set by the first failed check

   fixed_word_type        fixed_q[$];        // expected result transactions, oldest first

   // traffic shaping, percent of cycles spent idle / stalled
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_idle_pct  = 0;
   int unsigned           rsp_hold_pending = 0;
   int unsigned           rsp_hold_left    = 0;

   int unsigned           fail_count    = 0;
   int unsigned           words_sent    = 0;
   int unsigned           words_checked = 0;
   int unsigned           records_sent  = 0;
   int unsigned           replaced_seen = 0;
   int unsigned           mismatch_seen = 0;
   int unsigned           long_holds    = 0;

   function automatic void clear_fixup_record();
      rec_pos       = '0;
      usa_offset    = '0;
      usa_count     = '0;
      usa_filled    = 0;
      sectors_seen  = 0;
      fixup_stopped = 1'b0;
   endfunction

   // Advance the predictor by one accepted word and return what must come out.
   function automatic fixed_word_type fix_word(input logic [WORD_W-1:0] w, input logic l);
      fixed_word_type r;
      int unsigned pos, idx, entry;
      pos        = 32'(rec_pos);
      r.word     = w;
      r.last     = l;
      r.replaced = 1'b0;
      r.mismatch = 1'b0;

      // header fields; an odd byte offset loses its low bit
      if (pos == POS_SEQ_OFFSET)
         usa_offset = w[WORD_W-1:1];
      else if (pos == POS_SEQ_COUNT)
         usa_count = w;

      // sequence capture, never from the header words themselves
      if (pos >= POS_FIRST_BODY && pos >= usa_offset) begin
         idx = pos - usa_offset;
         if (idx < usa_count && idx <= MAX_SECTORS) begin
            usa_words[USA_IDX_W'(idx)] = w;
            if (usa_filled < idx + 1)
               usa_filled = idx + 1;
         end
      end

      // sector end: sector k is checked against entry 0 and patched from entry k+1
      if (pos % sector_len == sector_len - 1) begin
         entry = sectors_seen + 1;
         if (!fixup_stopped && entry < usa_count && entry <= MAX_SECTORS) begin
            if (usa_filled > entry && w == usa_words[0]) begin
               r.word     = usa_words[USA_IDX_W'(entry)];
               r.replaced = 1'b1;
            end else begin
               r.mismatch    = 1'b1;
               fixup_stopped = 1'b1;
            end
         end
         if (sectors_seen < MAX_SECTORS)
            sectors_seen++;
      end

      if (l)
         clear_fixup_record();
      else
         rec_pos = rec_pos + 1'b1;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Clock, reset, limit
   // -------------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop; the slowest legal run is well under a tenth of this
   initial begin
      #8ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls, plus long hold-offs counted here so the block
   // backs up and has to stall the sender
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_pending != 0) begin
         rsp_hold_left    = rsp_hold_pending;
         rsp_hold_pending = 0;
         long_holds++;
      end
      if (rsp_hold_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Result checker: every accepted rsp transaction against the oldest expectation
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      fixed_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fixed_q.size() == 0) begin
            $error("result with nothing expected: out_word %h", rsp_out_word);
            fail_count++;
         end else begin
            want = fixed_q.pop_front();
            words_checked++;
            if (rsp_out_word !== want.word) begin
               $error("out_word: expected %h, got %h", want.word, rsp_out_word);
               fail_count++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %b, got %b", want.last, rsp_out_last);
               fail_count++;
            end
            if (rsp_replaced !== want.replaced) begin
               $error("replaced: expected %b, got %b", want.replaced, rsp_replaced);
               fail_count++;
            end
            if (rsp_mismatch !== want.mismatch) begin
               $error("mismatch: expected %b, got %b", want.mismatch, rsp_mismatch);
               fail_count++;
            end
            if (want.replaced)
               replaced_seen++;
            if (want.mismatch)
               mismatch_seen++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------
   // One req transaction. Valid stays high into the next call unless a gap is
   // drawn, so it is never dropped and raised within one step.
   task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_word <= w;
      req_last_word <= l;
      do @(posedge clock); while (req_stall);
      fixed_q.push_back(fix_word(w, l));
      words_sent++;
   endtask

   // Build a record: header words 2/3, sequence word 0 at the offset, random
   // body, sector ends carrying the sequence number unless chosen to be bad.
   task automatic send_record(input int unsigned n_words, input logic [WORD_W-1:0] off_bytes,
                              input logic [WORD_W-1:0] cnt, input logic [WORD_W-1:0] usn,
                              input int bad_sector, input int unsigned bad_pct);
      logic [WORD_W-1:0] p, w;
      int unsigned       off_w;
      off_w = 32'(off_bytes >> 1);
      for (int unsigned i = 0; i < n_words; i++) begin
         p = i[WORD_W-1:0];
         w = WORD_W'($urandom);
         if (p == POS_SEQ_OFFSET)
            w = off_bytes;
         else if (p == POS_SEQ_COUNT)
            w = cnt;
         else if (p >= POS_FIRST_BODY && p == off_w)
            w = usn;
         if (p % sector_len == sector_len - 1) begin
            if (int'(i / sector_len) == bad_sector || $urandom_range(99) < bad_pct)
               w = usn ^ WORD_W'($urandom_range(65535, 1));
            else
               w = usn;
         end
         send_word(w, i == n_words - 1);
      end
      records_sent++;
   endtask

   // Mostly well-formed records with random content; the rest broken or noise.
   task automatic send_random_record();
      int unsigned       pick, nsec, len, off_w;
      logic [WORD_W-1:0] cnt, usn, off_bytes;
      pick  = $urandom_range(99);
      nsec  = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 4);
      len   = nsec * sector_len;
      usn   = WORD_W'($urandom);
      off_w = $urandom_range(4, 5);
      cnt   = WORD_W'(nsec + 1);
      off_bytes = WORD_W'(off_w * 2);
      if (pick < 70) begin
         if ($urandom_range(9) == 0)
            len = $urandom_range(1, len);          // record cut short mid-sector
         send_record(len, off_bytes, cnt, usn, -1, 3);
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: off_bytes = off_bytes + 1'b1;                     // odd byte offset
            1: off_bytes = WORD_W'($urandom_range(7));           // inside the header
            2: off_bytes = WORD_W'(2 * sector_len + $urandom_range(31)); // after sector end
            default: cnt = ($urandom_range(1) == 0) ? WORD_W'($urandom_range(15))
                                                    : WORD_W'($urandom);
         endcase
         send_record(len, off_bytes, cnt, usn, -1, 20);
      end else begin
         send_record($urandom_range(1, 2 * sector_len), WORD_W'($urandom),
                     WORD_W'($urandom), usn, -1, 50);
      end
   endtask

   task automatic run_random_phase(input int unsigned n_items, input bit with_holds);
      int unsigned first;
      first = words_sent;
      if (with_holds)
         rsp_hold_pending = 150;                  // long hold-off while the sender pushes on
      while (words_sent - first < n_items) begin
         if (with_holds && $urandom_range(7) == 0)
            rsp_hold_pending = $urandom_range(40, 120);
         send_random_record();
      end
   endtask

   // Let every expected transaction arrive, then a few more cycles of quiet.
   task automatic wait_idle();
      int unsigned n;
      n = 0;
      req_valid <= 1'b0;
      while (fixed_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (fixed_q.size() != 0) begin
         $error("%0d expected results never arrived", fixed_q.size());
         fail_count++;
         fixed_q.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Configuration port
   // -------------------------------------------------------------------------
   // Setup, access, then idle, so back-to-back accesses never
   // drive the bus twice in one step.
   task automatic csr_access(input logic [CSR_ADDR_W-1:0] addr, input logic wr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_sector_words();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(ADDR_SECTOR_WORDS, 1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(sector_len)) begin
         $error("sector_words: expected %0d, got %0d", sector_len, rd);
         fail_count++;
      end
   endtask

   // Only the low 12 bits count; out-of-range sizes saturate to 16..2048.
   task automatic set_sector_words(input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      logic [SECTOR_W-1:0]   v;
      csr_access(ADDR_SECTOR_WORDS, 1'b1, value, rd);
      v = value[SECTOR_W-1:0];
      if (v < SECTOR_WORDS_MIN)
         v = SECTOR_WORDS_MIN;
      if (v > SECTOR_WORDS_MAX)
         v = SECTOR_WORDS_MAX;
      sector_len = 32'(v);
      check_sector_words();
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Reset size of 256 words; this record also fills all nine sequence entries,
   // so later records that reuse old entries never see an unwritten one.
   task automatic test_reset_value();
      check_sector_words();
      send_record(256, 8, WORD_W'(MAX_SECTORS + 1), 16'hA5C3, -1, 0);
      wait_idle();
   endtask

   task automatic test_register_limits();
      logic [CSR_DATA_W-1:0] rd;
      set_sector_words(32'd0);
      set_sector_words(32'hFFFF_FFFF);
      set_sector_words(32'd15);
      set_sector_words(32'd2049);
      set_sector_words(32'd2047);
      csr_access(ADDR_UNMAPPED, 1'b1, $urandom, rd);  // must leave the size alone
      check_sector_words();
      set_sector_words(32'hABCD_E010);                // upper bits ignored -> 16
   endtask

   task automatic test_directed_records();
      send_record(48, 8, 4, 16'hFFFF, -1, 0);    // three sectors patched
      send_record(48, 8, 4, 16'h0000, 1, 0);     // second sector bad, third untouched
      send_record(32, 8, 0, 16'h1234, -1, 0);    // count zero
      send_record(32, 8, 1, 16'h1234, -1, 0);    // count one
      send_record(32, 2, 3, 16'h5A5A, -1, 0);    // sequence in header, uncaptured
      send_record(32, 4, 10, 16'h5A5A, -1, 0);   // header offset, later entries captured
      send_record(32, 9, 3, 16'hC001, -1, 0);    // odd byte offset
      send_record(32, 40, 3, 16'hBEEF, -1, 0);   // sector end before capture
      send_record(160, 8, 12, 16'h7FFF, -1, 0);  // more sectors than MAX_SECTORS
      send_record(1, 8, 3, 16'h8000, -1, 0);     // single-word record
      send_record(3, 8, 3, 16'h8000, -1, 0);     // ends before the count word
      send_record(20, 8, 3, 16'h0F0F, -1, 0);    // ends mid-sector
      wait_idle();
   endtask

   task automatic test_receiver_slow();
      send_idle_pct = 25;
      rsp_idle_pct  = 67;
      run_random_phase(220, 1'b0);
      wait_idle();
   endtask

   task automatic test_sender_slow();
      send_idle_pct = 67;
      rsp_idle_pct  = 25;
      set_sector_words(($urandom & 32'hFFFF_F000) | $urandom_range(17, 40));
      run_random_phase(220, 1'b0);
      wait_idle();
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_sector_words(32'd16);
      run_random_phase(220, 1'b1);
      wait_idle();
   endtask

   // -------------------------------------------------------------------------
   // Sequence of tests
   // -------------------------------------------------------------------------
   initial begin
      sector_len = 32'(SECTOR_WORDS_RESET);
      for (int i = 0; i <= MAX_SECTORS; i++)
         usa_words[USA_IDX_W'(i)] = '0;
      clear_fixup_record();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_value();
      test_register_limits();
      test_directed_records();
      test_receiver_slow();
      test_sender_slow();
      test_full_rate();

      $display("Ran %0d records, %0d words checked: %0d sector words patched, %0d mismatches.",
               records_sent, words_checked, replaced_seen, mismatch_seen);
      $display("Size register saturation, sizes 16 to 256 in traffic, %0d long hold-offs.",
               long_holds);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/rsf_pkg.sv
hdl/rsf_seq_ram.sv
hdl/rsf_track.sv
hdl/rsf_out.sv
hdl/record_sector_fixup_unit.sv
hdl/rsf_checker.sv
tb/testbench.sv
